>>> design/yuv_color_equalizer_assert.svh
// Assertion macros for the YUV color equalizer.
// Depends on clk and rst_n being visible in the including module.
`ifndef YUV_COLOR_EQUALIZER_ASSERT_SVH
`define YUV_COLOR_EQUALIZER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define YCE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles
`define YCE_ASSERT_DLY(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

>>> design/yce_pkg.sv
// Shared types and constants for the YUV color equalizer.
// No dependencies; imported by every module of the block.
package yce_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COS_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_GAIN    = 3'd4;

  // Item kinds
  localparam logic OP_LUMA   = 1'b0;
  localparam logic OP_CHROMA = 1'b1;

  // Field widths
  localparam int GAIN_W = 10;
  localparam int OFF_W  = 17;
  localparam int COEF_W = 11;
  localparam int CTR_W  = 9;   // centered sample, signed
  localparam int PROD_W = 19;  // one product, signed
  localparam int ACC_W  = 21;  // sum of products plus offset and rounding

  // Fixed-point constants
  localparam logic signed [CTR_W-1:0] LUMA_BLACK = 9'sd16;
  localparam logic signed [CTR_W-1:0] CHROMA_MID = 9'sd128;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 21'sd128;

  typedef struct packed {
    logic                     enable;
    logic [GAIN_W-1:0]        luma_gain;
    logic signed [OFF_W-1:0]  luma_offset;
    logic signed [COEF_W-1:0] cos_gain;
    logic signed [COEF_W-1:0] sin_gain;
  } cfg_t;

  // Stage 1: centered samples
  typedef struct packed {
    logic                    valid;
    logic                    kind;
    logic                    enable;
    logic signed [CTR_W-1:0] ym;
    logic signed [CTR_W-1:0] um;
    logic signed [CTR_W-1:0] vm;
    logic [7:0]              y;
    logic [7:0]              cb;
    logic [7:0]              cr;
  } s1_t;

  // Stage 2: products
  typedef struct packed {
    logic                     valid;
    logic                     kind;
    logic                     enable;
    logic signed [PROD_W-1:0] py;
    logic signed [PROD_W-1:0] uc;
    logic signed [PROD_W-1:0] vs;
    logic signed [PROD_W-1:0] vc;
    logic signed [PROD_W-1:0] us;
    logic [7:0]               y;
    logic [7:0]               cb;
    logic [7:0]               cr;
  } s2_t;

  // Output stage
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
  } res_t;

endpackage

>>> design/yuv_color_equalizer.sv
// YUV brightness, contrast, hue and saturation adjustment, three-stage pipeline.
// Throughput: one luma sample or chroma pair per cycle; busy is never raised.
// Stages: centering, multiplier stage (gain and rotation products), round/saturate.
// Results are shown for one cycle; the receiver cannot stall the pipeline.
// Synchronous active-low reset empties the pipeline and loads neutral settings.
module yuv_color_equalizer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_opcode,
  input  logic [7:0]                     in_luma_in,
  input  logic [7:0]                     in_cb_in,
  input  logic [7:0]                     in_cr_in,
  output logic                           out_valid,
  output logic                           out_kind,
  output logic [7:0]                     out_luma_out,
  output logic [7:0]                     out_cb_out,
  output logic [7:0]                     out_cr_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [yce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [yce_pkg::CFG_DATA_W-1:0] cfg_data
);
  import yce_pkg::*;

  `include "yuv_color_equalizer_assert.svh"

  cfg_t cfg_r;
  s1_t  s1;
  s2_t  s2;
  res_t res;
  logic take;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign take      = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable      <= 1'b0;
      cfg_r.luma_gain   <= 10'd256;
      cfg_r.luma_offset <= 17'sd0;
      cfg_r.cos_gain    <= 11'sd256;
      cfg_r.sin_gain    <= 11'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:      cfg_r.enable      <= cfg_data[0];
        REG_LUMA_GAIN:   cfg_r.luma_gain   <= cfg_data[GAIN_W-1:0];
        REG_LUMA_OFFSET: cfg_r.luma_offset <= signed'(cfg_data[OFF_W-1:0]);
        REG_COS_GAIN:    cfg_r.cos_gain    <= signed'(cfg_data[COEF_W-1:0]);
        REG_SIN_GAIN:    cfg_r.sin_gain    <= signed'(cfg_data[COEF_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  yce_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .opcode  (in_opcode),
    .luma_in (in_luma_in),
    .cb_in   (in_cb_in),
    .cr_in   (in_cr_in),
    .enable  (cfg_r.enable),
    .s1      (s1)
  );

  yce_mult u_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .s1    (s1),
    .cfg   (cfg_r),
    .s2    (s2)
  );

  yce_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .s2    (s2),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign out_valid    = res.valid;
  assign out_kind     = res.kind;
  assign out_luma_out = res.luma;
  assign out_cb_out   = res.cb;
  assign out_cr_out   = res.cr;

  // Checks
  `YCE_ASSERT_DLY(a_latency, take, 3, out_valid, "accepted item did not emerge after 3 cycles")
  `YCE_ASSERT_IMP(a_no_phantom, out_valid, $past(take, 3), "result without a matching transfer")
  `YCE_ASSERT_IMP(a_luma_zero, out_valid && (out_kind == OP_LUMA), (out_cb_out == 8'd0) && (out_cr_out == 8'd0), "luma result has nonzero chroma")
  `YCE_ASSERT_IMP(a_chroma_zero, out_valid && (out_kind == OP_CHROMA), out_luma_out == 8'd0, "chroma result has nonzero luma")

endmodule

>>> design/yce_prep.sv
// Stage 1: captures an item and centers luma and chroma samples.
// Depends on yce_pkg.
module yce_prep (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic        opcode,
  input  logic [7:0]  luma_in,
  input  logic [7:0]  cb_in,
  input  logic [7:0]  cr_in,
  input  logic        enable,
  output yce_pkg::s1_t s1
);
  import yce_pkg::*;

  s1_t s1_r;
  s1_t s1_nxt;

  // Remove the black level from luma and the midpoint from chroma
  always_comb begin
    s1_nxt.valid  = take;
    s1_nxt.kind   = opcode;
    s1_nxt.enable = enable;
    s1_nxt.ym     = signed'({1'b0, luma_in}) - LUMA_BLACK;
    s1_nxt.um     = signed'({1'b0, cb_in}) - CHROMA_MID;
    s1_nxt.vm     = signed'({1'b0, cr_in}) - CHROMA_MID;
    s1_nxt.y      = luma_in;
    s1_nxt.cb     = cb_in;
    s1_nxt.cr     = cr_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

>>> design/yce_mult.sv
// Stage 2: luma gain product and the four chroma rotation products.
// Depends on yce_pkg.
module yce_mult (
  input  logic         clk,
  input  logic         rst_n,
  input  yce_pkg::s1_t s1,
  input  yce_pkg::cfg_t cfg,
  output yce_pkg::s2_t s2
);
  import yce_pkg::*;

  s2_t s2_r;
  s2_t s2_nxt;
  logic signed [CTR_W+COEF_W-1:0]  py_full;
  logic signed [CTR_W+COEF_W-1:0]  uc_full;
  logic signed [CTR_W+COEF_W-1:0]  vs_full;
  logic signed [CTR_W+COEF_W-1:0]  vc_full;
  logic signed [CTR_W+COEF_W-1:0]  us_full;
  logic signed [COEF_W-1:0]        gain_s;

  // Gain is unsigned; widen with a zero sign bit
  assign gain_s  = signed'({1'b0, cfg.luma_gain});
  assign py_full = s1.ym * gain_s;
  assign uc_full = s1.um * cfg.cos_gain;
  assign vs_full = s1.vm * cfg.sin_gain;
  assign vc_full = s1.vm * cfg.cos_gain;
  assign us_full = s1.um * cfg.sin_gain;

  // Products fit in PROD_W bits for every sample and coefficient
  always_comb begin
    s2_nxt.valid  = s1.valid;
    s2_nxt.kind   = s1.kind;
    s2_nxt.enable = s1.enable;
    s2_nxt.py     = py_full[PROD_W-1:0];
    s2_nxt.uc     = uc_full[PROD_W-1:0];
    s2_nxt.vs     = vs_full[PROD_W-1:0];
    s2_nxt.vc     = vc_full[PROD_W-1:0];
    s2_nxt.us     = us_full[PROD_W-1:0];
    s2_nxt.y      = s1.y;
    s2_nxt.cb     = s1.cb;
    s2_nxt.cr     = s1.cr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else begin
      s2_r <= s2_nxt;
    end
  end

  assign s2 = s2_r;

endmodule

>>> design/yce_round.sv
// Stage 3: sums, half-up rounding, saturation and the output register.
// Depends on yce_pkg.
module yce_round (
  input  logic          clk,
  input  logic          rst_n,
  input  yce_pkg::s2_t  s2,
  input  yce_pkg::cfg_t cfg,
  output yce_pkg::res_t res
);
  import yce_pkg::*;

  localparam int SH_W = ACC_W - 8;
  localparam int BI_W = SH_W + 1;

  res_t res_r;
  res_t res_nxt;
  logic signed [ACC_W-1:0] acc_y;
  logic signed [ACC_W-1:0] acc_u;
  logic signed [ACC_W-1:0] acc_v;
  logic signed [BI_W-1:0]  bias_y;
  logic signed [BI_W-1:0]  bias_u;
  logic signed [BI_W-1:0]  bias_v;
  logic [7:0]              sat_y;
  logic [7:0]              sat_u;
  logic [7:0]              sat_v;

  function automatic logic [7:0] sat8(input logic signed [BI_W-1:0] x);
    logic [7:0] r;
    if (x < 0) begin
      r = 8'd0;
    end else if (x > 255) begin
      r = 8'd255;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

  // Accumulate with the rounding half, then floor-divide by 256
  always_comb begin
    acc_y  = ACC_W'(s2.py) + ACC_W'(cfg.luma_offset) + ROUND_HALF;
    acc_u  = ACC_W'(s2.uc) + ACC_W'(s2.vs) + ROUND_HALF;
    acc_v  = ACC_W'(s2.vc) - ACC_W'(s2.us) + ROUND_HALF;
    bias_y = BI_W'(signed'(acc_y[ACC_W-1:8])) + BI_W'(LUMA_BLACK);
    bias_u = BI_W'(signed'(acc_u[ACC_W-1:8])) + BI_W'(CHROMA_MID);
    bias_v = BI_W'(signed'(acc_v[ACC_W-1:8])) + BI_W'(CHROMA_MID);
    sat_y  = sat8(bias_y);
    sat_u  = sat8(bias_u);
    sat_v  = sat8(bias_v);
  end

  // Select adjusted or raw samples; unused fields read as zero
  always_comb begin
    res_nxt.valid = s2.valid;
    res_nxt.kind  = s2.kind;
    res_nxt.luma  = 8'd0;
    res_nxt.cb    = 8'd0;
    res_nxt.cr    = 8'd0;
    if (s2.kind == OP_LUMA) begin
      res_nxt.luma = s2.enable ? sat_y : s2.y;
    end else begin
      res_nxt.cb = s2.enable ? sat_u : s2.cb;
      res_nxt.cr = s2.enable ? sat_v : s2.cr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
